FILE: sv/rasv_pkg.sv
package rasv_pkg;

   localparam int ANALOG_SCALE_DEF  = 5760;
   localparam int DIGITAL_SCALE_DEF = 1440;
   localparam int ANALOG_BITS_DEF   = 12;
   localparam int DIGITAL_BITS_DEF  = 14;

   // filter coefficients, Q25, and the integer rate scale RATE_MS
   localparam logic signed [31:0] CB0     = 32'sd79095;
   localparam logic signed [31:0] CB1     = 32'sd158190;
   localparam logic signed [31:0] CB2     = 32'sd79095;
   localparam logic signed [31:0] CA1     = -32'sd62345588;
   localparam logic signed [31:0] CA2     = 32'sd29107535;
   localparam logic signed [31:0] RATE_MS = 32'sd1000;

   localparam int DIV_W = 35;
   localparam int STEP_W = 5;

   localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] STEP_CONV_A   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_CONV_D   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_CONV_END = 5'd3;
   localparam logic [STEP_W-1:0] STEP_F_B0     = 5'd4;
   localparam logic [STEP_W-1:0] STEP_F_PRE    = 5'd5;
   localparam logic [STEP_W-1:0] STEP_F_PRE2   = 5'd6;
   localparam logic [STEP_W-1:0] STEP_F_B1     = 5'd7;
   localparam logic [STEP_W-1:0] STEP_F_A1H    = 5'd8;
   localparam logic [STEP_W-1:0] STEP_F_A1L    = 5'd9;
   localparam logic [STEP_W-1:0] STEP_F_A2H    = 5'd10;
   localparam logic [STEP_W-1:0] STEP_F_A2L    = 5'd11;
   localparam logic [STEP_W-1:0] STEP_R_MA     = 5'd12;
   localparam logic [STEP_W-1:0] STEP_R_MD     = 5'd13;
   localparam logic [STEP_W-1:0] STEP_R_START  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_R_WAIT   = 5'd15;
   localparam logic [STEP_W-1:0] STEP_R_SAVE   = 5'd16;
   localparam logic [STEP_W-1:0] STEP_FINISH   = 5'd17;

   localparam logic [2:0] REG_ANALOG_MID  = 3'd0;
   localparam logic [2:0] REG_DIGITAL_MID = 3'd1;
   localparam logic [2:0] REG_ANALOG_LO   = 3'd2;
   localparam logic [2:0] REG_ANALOG_HI   = 3'd3;
   localparam logic [2:0] REG_DIGITAL_LO  = 3'd4;
   localparam logic [2:0] REG_DIGITAL_HI  = 3'd5;
   localparam logic [2:0] REG_RATE_LIMIT  = 3'd6;
   localparam logic [2:0] REG_AGREE_TOL   = 3'd7;

   typedef struct packed {
      logic [11:0] analog_raw;
      logic [13:0] digital_raw;
      logic        encoder_error;
      logic [31:0] time_ms;
   } req_item_type;

   typedef struct packed {
      logic signed [23:0] steer_angle;
      logic               angle_valid;
      logic signed [23:0] analog_angle;
      logic signed [23:0] digital_angle;
      logic signed [31:0] analog_rate;
      logic signed [31:0] digital_rate;
      logic               analog_out_of_range;
      logic               digital_out_of_range;
      logic               analog_rate_exceeded;
      logic               digital_rate_exceeded;
      logic               sensors_disagree;
      logic               both_failed;
   } rsp_item_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              capture;
   } cmd_type;

   typedef struct packed {
      logic run_filter;
      logic div_done;
      logic out_free;
   } status_type;

   // round to nearest, ties up, then arithmetic shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                 input int unsigned bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage

FILE: sv/rasv_req_if.sv
interface rasv_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] analog_raw;
   logic [13:0] digital_raw;
   logic        encoder_error;
   logic [31:0] time_ms;

   modport source (output valid, output analog_raw, output digital_raw,
                   output encoder_error, output time_ms, input ready);
   modport sink (input valid, input analog_raw, input digital_raw,
                 input encoder_error, input time_ms, output ready);
endinterface

FILE: sv/rasv_rsp_if.sv
interface rasv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] steer_angle;
   logic               angle_valid;
   logic signed [23:0] analog_angle;
   logic signed [23:0] digital_angle;
   logic signed [31:0] analog_rate;
   logic signed [31:0] digital_rate;
   logic               analog_out_of_range;
   logic               digital_out_of_range;
   logic               analog_rate_exceeded;
   logic               digital_rate_exceeded;
   logic               sensors_disagree;
   logic               both_failed;

   modport source (output valid, output steer_angle, output angle_valid,
                   output analog_angle, output digital_angle, output analog_rate,
                   output digital_rate, output analog_out_of_range,
                   output digital_out_of_range, output analog_rate_exceeded,
                   output digital_rate_exceeded, output sensors_disagree,
                   output both_failed, input ready);
   modport sink (input valid, input steer_angle, input angle_valid,
                 input analog_angle, input digital_angle, input analog_rate,
                 input digital_rate, input analog_out_of_range,
                 input digital_out_of_range, input analog_rate_exceeded,
                 input digital_rate_exceeded, input sensors_disagree,
                 input both_failed, output ready);
endinterface

FILE: sv/rasv_divider.sv
module rasv_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rasv_pkg::DIV_W-1:0]   dividend,
   input  logic [31:0]                  divisor,
   output logic                         busy,
   output logic [rasv_pkg::DIV_W-1:0]   quotient
);
   localparam int CNT_W = $clog2(rasv_pkg::DIV_W);

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [31:0]                rem_ff, rem_in;
   logic [31:0]                dsr_ff, dsr_in;
   logic [rasv_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [32:0]                shifted;
   logic [32:0]                diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[rasv_pkg::DIV_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(rasv_pkg::DIV_W - 1);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[rasv_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[rasv_pkg::DIV_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

FILE: sv/rasv_ctrl.sv
module rasv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rasv_pkg::status_type status,
   output rasv_pkg::cmd_type    cmd
);
   logic [rasv_pkg::STEP_W-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rasv_pkg::STEP_IDLE: begin
            if (req_valid) begin
               state_in = rasv_pkg::STEP_CONV_A;
            end
         end
         rasv_pkg::STEP_CONV_A:   state_in = rasv_pkg::STEP_CONV_D;
         rasv_pkg::STEP_CONV_D:   state_in = rasv_pkg::STEP_CONV_END;
         rasv_pkg::STEP_CONV_END: begin
            state_in = status.run_filter ? rasv_pkg::STEP_F_B0 : rasv_pkg::STEP_FINISH;
         end
         rasv_pkg::STEP_F_B0:     state_in = rasv_pkg::STEP_F_PRE;
         rasv_pkg::STEP_F_PRE:    state_in = rasv_pkg::STEP_F_PRE2;
         rasv_pkg::STEP_F_PRE2:   state_in = rasv_pkg::STEP_F_B1;
         rasv_pkg::STEP_F_B1:     state_in = rasv_pkg::STEP_F_A1H;
         rasv_pkg::STEP_F_A1H:    state_in = rasv_pkg::STEP_F_A1L;
         rasv_pkg::STEP_F_A1L:    state_in = rasv_pkg::STEP_F_A2H;
         rasv_pkg::STEP_F_A2H:    state_in = rasv_pkg::STEP_F_A2L;
         rasv_pkg::STEP_F_A2L:    state_in = rasv_pkg::STEP_R_MA;
         rasv_pkg::STEP_R_MA:     state_in = rasv_pkg::STEP_R_MD;
         rasv_pkg::STEP_R_MD:     state_in = rasv_pkg::STEP_R_START;
         rasv_pkg::STEP_R_START:  state_in = rasv_pkg::STEP_R_WAIT;
         rasv_pkg::STEP_R_WAIT: begin
            if (status.div_done) begin
               state_in = rasv_pkg::STEP_R_SAVE;
            end
         end
         rasv_pkg::STEP_R_SAVE:   state_in = rasv_pkg::STEP_FINISH;
         rasv_pkg::STEP_FINISH: begin
            if (status.out_free) begin
               state_in = rasv_pkg::STEP_IDLE;
            end
         end
         default:                 state_in = rasv_pkg::STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rasv_pkg::STEP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == rasv_pkg::STEP_IDLE);
   assign cmd.step    = state_ff;
   assign cmd.capture = req_valid && (state_ff == rasv_pkg::STEP_IDLE);
endmodule

FILE: sv/rasv_datapath.sv
module rasv_datapath #(
   parameter int ANALOG_SCALE  = rasv_pkg::ANALOG_SCALE_DEF,
   parameter int DIGITAL_SCALE = rasv_pkg::DIGITAL_SCALE_DEF,
   parameter int ANALOG_BITS   = rasv_pkg::ANALOG_BITS_DEF,
   parameter int DIGITAL_BITS  = rasv_pkg::DIGITAL_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [30:0]            csr_wdata,
   input  rasv_pkg::req_item_type req_item,
   input  rasv_pkg::cmd_type      cmd,
   output rasv_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rasv_pkg::rsp_item_type rsp_item
);
   localparam logic [15:0] AMASK = 16'((32'd1 << ANALOG_BITS) - 32'd1);
   localparam logic [15:0] DMASK = 16'((32'd1 << DIGITAL_BITS) - 32'd1);
   localparam logic signed [31:0] ASCALE = 32'(ANALOG_SCALE);
   localparam logic signed [31:0] DSCALE = 32'(DIGITAL_SCALE);
   localparam logic signed [31:0] CPRE   = rasv_pkg::CB2 - rasv_pkg::CA2;

   // configuration
   logic [11:0] amid_ff, alo_ff, ahi_ff;
   logic [13:0] dmid_ff, dlo_ff, dhi_ff;
   logic [30:0] rlim_ff;
   logic [22:0] tol_ff;

   // block state
   logic               first_ff, ready_ff;
   logic signed [47:0] d1_ff, d2_ff;
   logic [31:0]        rate_ts_ff;
   logic signed [23:0] base_a_ff, base_d_ff, held_a_ff, last_d_ff;
   logic signed [31:0] rate_a_ff, rate_d_ff;

   // working registers
   rasv_pkg::req_item_type in_ff;
   logic signed [63:0] prod_ff, acc_ff, t0_ff, rb1_ff, num_a_ff;
   logic signed [35:0] ys_ff;
   logic signed [23:0] raw_a_ff, dig_ff;
   logic               neg_a_ff, neg_d_ff;
   logic               out_valid_ff;
   rasv_pkg::rsp_item_type out_ff;

   logic signed [31:0] mul_a, mul_b;
   logic [15:0]        a_m, am_m, d_m, dm_m;
   logic signed [16:0] off_a, off_d;
   logic signed [31:0] xs;
   logic [31:0]        dt;
   logic               update;
   logic signed [63:0] t0_now, d1_eff, ys_full, p_round;
   logic [rasv_pkg::DIV_W-1:0] dvd_a, dvd_d, quo_a, quo_d;
   logic               busy_a, busy_d, div_start;
   logic signed [63:0] num_abs_a, num_abs_d;
   logic               out_free, finish_load;
   logic [32:0]        mag_ra, mag_rd;
   logic signed [24:0] adiff;
   logic [25:0]        mag_diff;
   logic               a_oor, d_oor, a_rx, d_rx, a_ok, d_ok;

   function automatic logic signed [31:0] rate_sat(input logic [rasv_pkg::DIV_W-1:0] q,
                                                    input logic neg);
      logic [rasv_pkg::DIV_W-1:0] lim;
      lim = rasv_pkg::DIV_W'(33'h080000000);
      if (neg) begin
         return (q > lim) ? 32'sh80000000 : -$signed(q[31:0]);
      end
      return (q >= lim) ? 32'sh7fffffff : $signed(q[31:0]);
   endfunction

   assign a_m   = 16'(in_ff.analog_raw) & AMASK;
   assign am_m  = 16'(amid_ff) & AMASK;
   assign d_m   = 16'(in_ff.digital_raw) & DMASK;
   assign dm_m  = 16'(dmid_ff) & DMASK;
   assign off_a = $signed({1'b0, a_m}) - $signed({1'b0, am_m});
   assign off_d = $signed({1'b0, dm_m}) - $signed({1'b0, d_m});
   assign xs    = 32'(raw_a_ff) <<< 8;
   assign dt     = in_ff.time_ms - rate_ts_ff;
   assign update = dt > 32'd2;

   assign t0_now  = rasv_pkg::rnd_shift(prod_ff, 25);
   assign d1_eff  = ready_ff ? 64'(d1_ff) : (64'(xs) - t0_now);
   assign ys_full = rasv_pkg::sat_to(t0_now + d1_eff, 36);
   assign p_round = rasv_pkg::rnd_shift(acc_ff + prod_ff, 25);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         rasv_pkg::STEP_CONV_A: begin mul_a = 32'(off_a); mul_b = ASCALE; end
         rasv_pkg::STEP_CONV_D: begin mul_a = 32'(off_d); mul_b = DSCALE; end
         rasv_pkg::STEP_F_B0:   begin mul_a = rasv_pkg::CB0; mul_b = xs; end
         rasv_pkg::STEP_F_PRE:  begin mul_a = CPRE; mul_b = xs; end
         rasv_pkg::STEP_F_PRE2: begin mul_a = rasv_pkg::CB1; mul_b = xs; end
         rasv_pkg::STEP_F_B1: begin
            mul_a = rasv_pkg::CA1;
            mul_b = 32'($signed(ys_ff[35:18]));
         end
         rasv_pkg::STEP_F_A1H: begin
            mul_a = rasv_pkg::CA1;
            mul_b = $signed(32'({1'b0, ys_ff[17:0]}));
         end
         rasv_pkg::STEP_F_A1L: begin
            mul_a = rasv_pkg::CA2;
            mul_b = 32'($signed(ys_ff[35:18]));
         end
         rasv_pkg::STEP_F_A2H: begin
            mul_a = rasv_pkg::CA2;
            mul_b = $signed(32'({1'b0, ys_ff[17:0]}));
         end
         rasv_pkg::STEP_R_MA: begin
            mul_a = 32'(25'(held_a_ff) - 25'(base_a_ff));
            mul_b = rasv_pkg::RATE_MS;
         end
         rasv_pkg::STEP_R_MD: begin
            mul_a = 32'(25'(dig_ff) - 25'(base_d_ff));
            mul_b = rasv_pkg::RATE_MS;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign num_abs_a = num_a_ff[63] ? -num_a_ff : num_a_ff;
   assign num_abs_d = prod_ff[63] ? -prod_ff : prod_ff;
   assign dvd_a     = rasv_pkg::DIV_W'(num_abs_a) + rasv_pkg::DIV_W'(dt >> 1);
   assign dvd_d     = rasv_pkg::DIV_W'(num_abs_d) + rasv_pkg::DIV_W'(dt >> 1);
   assign div_start = (cmd.step == rasv_pkg::STEP_R_START);

   rasv_divider u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_a),
      .divisor  (dt),
      .busy     (busy_a),
      .quotient (quo_a)
   );

   rasv_divider u_div_d (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_d),
      .divisor  (dt),
      .busy     (busy_d),
      .quotient (quo_d)
   );

   // checks and selection
   assign mag_ra   = rate_a_ff[31] ? -33'(rate_a_ff) : 33'(rate_a_ff);
   assign mag_rd   = rate_d_ff[31] ? -33'(rate_d_ff) : 33'(rate_d_ff);
   assign adiff    = 25'(held_a_ff) - 25'(dig_ff);
   assign mag_diff = adiff[24] ? -26'(adiff) : 26'(adiff);
   assign a_rx     = mag_ra > {2'b0, rlim_ff};
   assign d_rx     = mag_rd > {2'b0, rlim_ff};
   assign a_oor    = (in_ff.analog_raw < alo_ff) || (in_ff.analog_raw > ahi_ff);
   assign d_oor    = (in_ff.digital_raw < dlo_ff) || (in_ff.digital_raw > dhi_ff);
   assign a_ok     = !a_oor && !a_rx;
   assign d_ok     = !d_oor && !d_rx && !in_ff.encoder_error;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign finish_load = (cmd.step == rasv_pkg::STEP_FINISH) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         amid_ff <= 12'd2048;
         dmid_ff <= 14'd8192;
         alo_ff  <= 12'd0;
         ahi_ff  <= 12'd4095;
         dlo_ff  <= 14'd0;
         dhi_ff  <= 14'd16383;
         rlim_ff <= 31'h7fffffff;
         tol_ff  <= 23'd2560;
      end else if (csr_we) begin
         unique case (csr_index)
            rasv_pkg::REG_ANALOG_MID:  amid_ff <= csr_wdata[11:0];
            rasv_pkg::REG_DIGITAL_MID: dmid_ff <= csr_wdata[13:0];
            rasv_pkg::REG_ANALOG_LO:   alo_ff  <= csr_wdata[11:0];
            rasv_pkg::REG_ANALOG_HI:   ahi_ff  <= csr_wdata[11:0];
            rasv_pkg::REG_DIGITAL_LO:  dlo_ff  <= csr_wdata[13:0];
            rasv_pkg::REG_DIGITAL_HI:  dhi_ff  <= csr_wdata[13:0];
            rasv_pkg::REG_RATE_LIMIT:  rlim_ff <= csr_wdata;
            rasv_pkg::REG_AGREE_TOL:   tol_ff  <= csr_wdata[22:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         in_ff <= req_item;
      end
      unique case (cmd.step)
         rasv_pkg::STEP_CONV_D:
            raw_a_ff <= 24'(rasv_pkg::sat_to(rasv_pkg::rnd_shift(prod_ff, 8), 24));
         rasv_pkg::STEP_CONV_END:
            dig_ff <= 24'(rasv_pkg::sat_to(rasv_pkg::rnd_shift(prod_ff, 8), 24));
         rasv_pkg::STEP_F_PRE: begin
            t0_ff <= t0_now;
            ys_ff <= 36'(ys_full);
         end
         rasv_pkg::STEP_F_B1:  rb1_ff <= t0_now;
         rasv_pkg::STEP_F_A1H: acc_ff <= prod_ff <<< 18;
         rasv_pkg::STEP_F_A2H: acc_ff <= prod_ff <<< 18;
         rasv_pkg::STEP_R_MD:  num_a_ff <= prod_ff;
         rasv_pkg::STEP_R_START: begin
            neg_a_ff <= num_a_ff[63];
            neg_d_ff <= prod_ff[63];
         end
         default: acc_ff <= acc_ff;
      endcase
      if (finish_load) begin
         out_ff.angle_valid  <= !first_ff;
         out_ff.analog_angle <= held_a_ff;
         out_ff.digital_angle <= dig_ff;
         out_ff.analog_rate  <= rate_a_ff;
         out_ff.digital_rate <= rate_d_ff;
         if (first_ff) begin
            out_ff.steer_angle           <= '0;
            out_ff.analog_out_of_range   <= 1'b0;
            out_ff.digital_out_of_range  <= 1'b0;
            out_ff.analog_rate_exceeded  <= 1'b0;
            out_ff.digital_rate_exceeded <= 1'b0;
            out_ff.sensors_disagree      <= 1'b0;
            out_ff.both_failed           <= 1'b0;
         end else begin
            out_ff.analog_out_of_range   <= a_oor;
            out_ff.digital_out_of_range  <= d_oor;
            out_ff.analog_rate_exceeded  <= a_rx;
            out_ff.digital_rate_exceeded <= d_rx;
            out_ff.sensors_disagree      <= mag_diff > {3'b0, tol_ff};
            out_ff.both_failed           <= !d_ok && !a_ok;
            priority if (d_ok) begin
               out_ff.steer_angle <= dig_ff;
            end else if (a_ok) begin
               out_ff.steer_angle <= held_a_ff;
            end else begin
               out_ff.steer_angle <= last_d_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         ready_ff     <= 1'b0;
         d1_ff        <= '0;
         d2_ff        <= '0;
         rate_ts_ff   <= '0;
         base_a_ff    <= '0;
         base_d_ff    <= '0;
         held_a_ff    <= '0;
         last_d_ff    <= '0;
         rate_a_ff    <= '0;
         rate_d_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.step == rasv_pkg::STEP_F_PRE && !ready_ff) begin
            d1_ff <= 48'(xs - 32'(t0_now));
         end
         if (cmd.step == rasv_pkg::STEP_F_PRE2 && !ready_ff) begin
            d2_ff    <= 48'(t0_now);
            ready_ff <= 1'b1;
         end
         if (cmd.step == rasv_pkg::STEP_F_A1L) begin
            d1_ff <= 48'(rasv_pkg::sat_to(rb1_ff - p_round + 64'(d2_ff), 48));
         end
         if (cmd.step == rasv_pkg::STEP_F_A2L) begin
            d2_ff     <= 48'(rasv_pkg::sat_to(t0_ff - p_round, 48));
            held_a_ff <= 24'(rasv_pkg::sat_to(rasv_pkg::rnd_shift(64'(ys_ff), 8), 24));
         end
         if (cmd.step == rasv_pkg::STEP_R_SAVE) begin
            rate_a_ff <= rate_sat(quo_a, neg_a_ff);
            rate_d_ff <= rate_sat(quo_d, neg_d_ff);
         end
         if (finish_load) begin
            if (update) begin
               rate_ts_ff <= in_ff.time_ms;
               base_a_ff  <= held_a_ff;
               base_d_ff  <= dig_ff;
            end
            last_d_ff <= dig_ff;
            first_ff  <= 1'b0;
         end
         if (finish_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.run_filter = !first_ff && update;
   assign status.div_done   = !busy_a && !busy_d;
   assign status.out_free   = out_free;
   assign rsp_valid         = out_valid_ff;
   assign rsp_item          = out_ff;
endmodule

FILE: sv/redundant_angle_sensor_voter_core.sv
// Redundant steering angle voter.
// req_ch carries one item per sensor sample: analog ADC count, encoder count,
// encoder error flag and a millisecond timestamp. rsp_ch returns one item per
// request with the selected angle, both sensor angles and rates, and flags.
// csr_we/csr_index/csr_wdata write the midpoints, limits, rate limit and
// agreement tolerance; write them only while no item is in flight.
// Without a rate update (first sample, or 2 ms or less since the last update)
// an item runs the 3 conversion steps and then the finish step. With an update
// it runs 3 conversion steps, 8 filter steps on the shared 32x32 multiplier,
// the rate multiply steps and the two bit-serial rate dividers, which run side
// by side, and 2 closing steps.
// Loading the result returns the controller to idle, ready for the next item.
// Reset (synchronous) restores register defaults, marks the next sample as
// the first and clears the filter, rate bases and held values.
// The result sits in an output register; while rsp_ch is stalled with a
// result pending, a new item may be accepted and worked on, and it waits
// in its final step until the output register is free.
module redundant_angle_sensor_voter_core #(
   parameter int ANALOG_SCALE  = rasv_pkg::ANALOG_SCALE_DEF,
   parameter int DIGITAL_SCALE = rasv_pkg::DIGITAL_SCALE_DEF,
   parameter int ANALOG_BITS   = rasv_pkg::ANALOG_BITS_DEF,
   parameter int DIGITAL_BITS  = rasv_pkg::DIGITAL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rasv_req_if.sink    req_ch,
   rasv_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   rasv_pkg::cmd_type      cmd;
   rasv_pkg::status_type   status;
   rasv_pkg::req_item_type req_item;
   rasv_pkg::rsp_item_type rsp_item;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_item.analog_raw    = req_ch.analog_raw;
   assign req_item.digital_raw   = req_ch.digital_raw;
   assign req_item.encoder_error = req_ch.encoder_error;
   assign req_item.time_ms       = req_ch.time_ms;
   assign req_ch.ready           = req_ready;

   rasv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rasv_datapath #(
      .ANALOG_SCALE  (ANALOG_SCALE),
      .DIGITAL_SCALE (DIGITAL_SCALE),
      .ANALOG_BITS   (ANALOG_BITS),
      .DIGITAL_BITS  (DIGITAL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_ch.valid                 = rsp_valid;
   assign rsp_ch.steer_angle           = rsp_item.steer_angle;
   assign rsp_ch.angle_valid           = rsp_item.angle_valid;
   assign rsp_ch.analog_angle          = rsp_item.analog_angle;
   assign rsp_ch.digital_angle         = rsp_item.digital_angle;
   assign rsp_ch.analog_rate           = rsp_item.analog_rate;
   assign rsp_ch.digital_rate          = rsp_item.digital_rate;
   assign rsp_ch.analog_out_of_range   = rsp_item.analog_out_of_range;
   assign rsp_ch.digital_out_of_range  = rsp_item.digital_out_of_range;
   assign rsp_ch.analog_rate_exceeded  = rsp_item.analog_rate_exceeded;
   assign rsp_ch.digital_rate_exceeded = rsp_item.digital_rate_exceeded;
   assign rsp_ch.sensors_disagree      = rsp_item.sensors_disagree;
   assign rsp_ch.both_failed           = rsp_item.both_failed;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("second item accepted while one is in flight");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.step == rasv_pkg::STEP_FINISH))
      else $error("result loaded outside the finish step");

   a_first_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.angle_valid |->
         rsp_ch.steer_angle == 24'sd0 && !rsp_ch.both_failed && !rsp_ch.sensors_disagree)
      else $error("first sample item carries an angle or flags");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.step == rasv_pkg::STEP_R_START |-> status.div_done)
      else $error("rate division started while dividers busy");
endmodule

FILE: sim/redundant_angle_sensor_voter_core_tb.sv
module redundant_angle_sensor_voter_core_tb;
   import rasv_pkg::*;

   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;

   class angle_scoreboard;
      logic [11:0] a_mid, a_lo, a_hi;
      logic [13:0] d_mid, d_lo, d_hi;
      logic [30:0] rate_lim;
      logic [22:0] tol;
      bit          first, fready;
      longint      d1, d2, base_a, base_d, held_a, last_d, rate_a, rate_d;
      bit [31:0]   stamp;
      rsp_item_type pending[$];
      int          errors;

      function new();
         a_mid = 2048; d_mid = 8192; a_lo = 0; a_hi = 4095; d_lo = 0; d_hi = 16383;
         rate_lim = 31'h7fff_ffff; tol = 2560;
         first = 1; fready = 0; d1 = 0; d2 = 0; stamp = 0;
         base_a = 0; base_d = 0; held_a = 0; last_d = 0; rate_a = 0; rate_d = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [30:0] v);
         case (idx)
            REG_ANALOG_MID:  a_mid = v[11:0];
            REG_DIGITAL_MID: d_mid = v[13:0];
            REG_ANALOG_LO:   a_lo = v[11:0];
            REG_ANALOG_HI:   a_hi = v[11:0];
            REG_DIGITAL_LO:  d_lo = v[13:0];
            REG_DIGITAL_HI:  d_hi = v[13:0];
            REG_RATE_LIMIT:  rate_lim = v;
            REG_AGREE_TOL:   tol = v[22:0];
            default: ;
         endcase
      endfunction

      function longint rsh(longint v, int n);
         return (v + (longint'(1) << (n - 1))) >>> n;
      endfunction

      function longint clip(longint v, int bits);
         longint hi, lo;
         hi = (longint'(1) << (bits - 1)) - 1;
         lo = -hi - 1;
         return v > hi ? hi : (v < lo ? lo : v);
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function longint low_pass(longint x);
         longint xs, ys, b0, b1, b2, a1, a2;
         b0 = longint'(CB0); b1 = longint'(CB1); b2 = longint'(CB2);
         a1 = longint'(CA1); a2 = longint'(CA2);
         xs = x * 256;
         if (!fready) begin
            d1 = xs - rsh(b0 * xs, 25);
            d2 = rsh((b2 - a2) * xs, 25);
            fready = 1;
         end
         ys = clip(rsh(b0 * xs, 25) + d1, 36);
         d1 = clip(rsh(b1 * xs, 25) - rsh(a1 * ys, 25) + d2, 48);
         d2 = clip(rsh(b2 * xs, 25) - rsh(a2 * ys, 25), 48);
         return clip(rsh(ys, 8), 24);
      endfunction

      function longint rate(longint delta, bit [31:0] dt);
         longint num, q, span;
         span = longint'({32'd0, dt});
         num = delta * 1000;
         q = (mag(num) + span / 2) / span;
         return clip(num < 0 ? -q : q, 32);
      endfunction

      function void note(req_item_type it);
         rsp_item_type e;
         longint ra, dig, ana, steer;
         bit [31:0] dt;
         bit upd, a_ok, d_ok;
         e = '0;
         ra = clip(rsh((longint'(it.analog_raw) - longint'(a_mid)) * ANALOG_SCALE_DEF, 8), 24);
         dig = clip(rsh((longint'(d_mid) - longint'(it.digital_raw)) * DIGITAL_SCALE_DEF, 8),
                    24);
         dt = it.time_ms - stamp;
         upd = dt > 2;
         ana = held_a;
         steer = 0;
         if (!first) begin
            if (upd) begin
               ana = low_pass(ra);
               rate_a = rate(ana - base_a, dt);
               rate_d = rate(dig - base_d, dt);
               held_a = ana;
            end
            e.analog_rate_exceeded = mag(rate_a) > longint'(rate_lim);
            e.digital_rate_exceeded = mag(rate_d) > longint'(rate_lim);
            e.analog_out_of_range = it.analog_raw < a_lo || it.analog_raw > a_hi;
            e.digital_out_of_range = it.digital_raw < d_lo || it.digital_raw > d_hi;
            e.sensors_disagree = mag(ana - dig) > longint'(tol);
            a_ok = !e.analog_out_of_range && !e.analog_rate_exceeded;
            d_ok = !e.digital_out_of_range && !e.digital_rate_exceeded && !it.encoder_error;
            if (d_ok) steer = dig;
            else if (a_ok) steer = ana;
            else begin
               steer = last_d;
               e.both_failed = 1;
            end
            e.angle_valid = 1;
         end
         if (upd) begin
            stamp = it.time_ms;
            base_a = ana;
            base_d = dig;
         end
         last_d = dig;
         first = 0;
         e.steer_angle = steer[23:0];
         e.analog_angle = ana[23:0];
         e.digital_angle = dig[23:0];
         e.analog_rate = rate_a[31:0];
         e.digital_rate = rate_d[31:0];
         pending.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      endtask

      task check(rsp_item_type g);
         rsp_item_type e;
         if (pending.size() == 0) begin
            report("unexpected item", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (g.steer_angle !== e.steer_angle) report("steer_angle", g.steer_angle, e.steer_angle);
         if (g.angle_valid !== e.angle_valid) report("angle_valid", g.angle_valid, e.angle_valid);
         if (g.analog_angle !== e.analog_angle)
            report("analog_angle", g.analog_angle, e.analog_angle);
         if (g.digital_angle !== e.digital_angle)
            report("digital_angle", g.digital_angle, e.digital_angle);
         if (g.analog_rate !== e.analog_rate) report("analog_rate", g.analog_rate, e.analog_rate);
         if (g.digital_rate !== e.digital_rate)
            report("digital_rate", g.digital_rate, e.digital_rate);
         if (g.analog_out_of_range !== e.analog_out_of_range)
            report("analog_out_of_range", g.analog_out_of_range, e.analog_out_of_range);
         if (g.digital_out_of_range !== e.digital_out_of_range)
            report("digital_out_of_range", g.digital_out_of_range, e.digital_out_of_range);
         if (g.analog_rate_exceeded !== e.analog_rate_exceeded)
            report("analog_rate_exceeded", g.analog_rate_exceeded, e.analog_rate_exceeded);
         if (g.digital_rate_exceeded !== e.digital_rate_exceeded)
            report("digital_rate_exceeded", g.digital_rate_exceeded, e.digital_rate_exceeded);
         if (g.sensors_disagree !== e.sensors_disagree)
            report("sensors_disagree", g.sensors_disagree, e.sensors_disagree);
         if (g.both_failed !== e.both_failed) report("both_failed", g.both_failed, e.both_failed);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   rasv_req_if req_bus();
   rasv_rsp_if rsp_bus();

   redundant_angle_sensor_voter_core u_dut (
      .clock(clock), .reset(reset), .req_ch(req_bus), .rsp_ch(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   angle_scoreboard sb = new();
   bit        idle_on = 1;
   bit        long_hold = 0;
   int        stall_left = 0;
   int        quiet = 0;
   bit [31:0] now_ms;
   int        walk_a;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.analog_raw = '0;
      req_bus.digital_raw = '0;
      req_bus.encoder_error = 0;
      req_bus.time_ms = '0;
      rsp_bus.ready = 0;
   end

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.steer_angle = rsp_bus.steer_angle;
         got.angle_valid = rsp_bus.angle_valid;
         got.analog_angle = rsp_bus.analog_angle;
         got.digital_angle = rsp_bus.digital_angle;
         got.analog_rate = rsp_bus.analog_rate;
         got.digital_rate = rsp_bus.digital_rate;
         got.analog_out_of_range = rsp_bus.analog_out_of_range;
         got.digital_out_of_range = rsp_bus.digital_out_of_range;
         got.analog_rate_exceeded = rsp_bus.analog_rate_exceeded;
         got.digital_rate_exceeded = rsp_bus.digital_rate_exceeded;
         got.sensors_disagree = rsp_bus.sensors_disagree;
         got.both_failed = rsp_bus.both_failed;
         sb.check(got);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // receiver side
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 0;
         end else begin
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 9);
            if (stall_left > 0) begin
               rsp_bus.ready <= 0;
               stall_left--;
            end else begin
               rsp_bus.ready <= 1;
            end
         end
      end
   end

   task send(req_item_type it);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.analog_raw <= it.analog_raw;
      req_bus.digital_raw <= it.digital_raw;
      req_bus.encoder_error <= it.encoder_error;
      req_bus.time_ms <= it.time_ms;
      do @(posedge clock); while (!req_bus.ready);
      sb.note(it);
   endtask

   task send_fields(int a, int d, bit err, bit [31:0] t);
      req_item_type it;
      it.analog_raw = a;
      it.digital_raw = d;
      it.encoder_error = err;
      it.time_ms = t;
      send(it);
   endtask

   task drain();
      @(negedge clock);
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [30:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task write_end();
      @(negedge clock);
      csr_we <= 0;
   endtask

   task setup(int am, int dm, int alo, int ahi, int dlo, int dhi, int rl, int tl);
      write_reg(REG_ANALOG_MID, am);
      write_reg(REG_DIGITAL_MID, dm);
      write_reg(REG_ANALOG_LO, alo);
      write_reg(REG_ANALOG_HI, ahi);
      write_reg(REG_DIGITAL_LO, dlo);
      write_reg(REG_DIGITAL_HI, dhi);
      write_reg(REG_RATE_LIMIT, rl);
      write_reg(REG_AGREE_TOL, tl);
      write_end();
   endtask

   // mostly a smooth sweep with consistent sensors, sometimes pure noise
   task random_item();
      int d;
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1)) now_ms = $urandom;
         else now_ms += $urandom_range(0, 3);
         send_fields($urandom_range(0, 4095), $urandom_range(0, 16383), $urandom_range(0, 1),
                     now_ms);
      end else begin
         now_ms += ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 25);
         walk_a += $urandom_range(0, 40) - 20;
         if (walk_a < 0) walk_a = 0;
         if (walk_a > 4095) walk_a = 4095;
         d = int'(sb.d_mid) - 4 * (walk_a - int'(sb.a_mid)) + $urandom_range(0, 16) - 8;
         if (d < 0) d = 0;
         if (d > 16383) d = 16383;
         send_fields(walk_a, d, $urandom_range(0, 19) == 0, now_ms);
      end
   endtask

   initial begin
      int rl;
      repeat (6) @(negedge clock);
      reset <= 0;

      // first sample, short interval, extremes, wrap of the timestamp
      send_fields(0, 16383, 0, 100);
      send_fields(4095, 0, 0, 101);
      send_fields(4095, 0, 0, 110);
      send_fields(0, 16383, 1, 120);
      send_fields(2048, 8192, 0, 130);
      send_fields(2048, 8192, 0, 130);
      send_fields(2050, 8184, 1, 140);
      send_fields(2100, 7990, 0, 32'hffff_fffe);
      send_fields(2100, 7990, 0, 5);
      send_fields(2100, 7990, 0, 32'h8000_0005);
      drain();

      setup(0, 16383, 100, 4000, 200, 16000, 0, 0);
      send_fields(50, 100, 0, 32'h8000_0010);
      send_fields(4095, 16383, 0, 32'h8000_0020);
      send_fields(2000, 8000, 1, 32'h8000_0030);
      send_fields(0, 0, 0, 32'h8000_0031);
      drain();

      setup(4095, 0, 4095, 0, 16383, 0, 31'h7fff_ffff, 8388607);
      send_fields(4095, 0, 0, 32'h8000_0040);
      send_fields(0, 16383, 0, 32'h8000_0050);
      send_fields(1234, 4321, 1, 32'h8000_0060);
      drain();

      now_ms = $urandom;
      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 2))
            0: rl = $urandom_range(0, 200000);
            1: rl = $urandom_range(200000, 5000000);
            default: rl = 31'h7fff_ffff;
         endcase
         setup($urandom_range(1500, 2600), $urandom_range(6000, 10000), $urandom_range(0, 300),
               $urandom_range(3800, 4095), $urandom_range(0, 1000),
               $urandom_range(15000, 16383), rl, $urandom_range(0, 20000));
         walk_a = sb.a_mid;
         for (int n = 0; n < 130; n++) begin
            if (n % 40 == 0) idle_on = (ph < 5) && ($urandom_range(0, 3) != 0);
            if (ph == 1 && n == 60) long_hold = 1;
            if (ph == 2 && n == 60) begin
               @(negedge clock);
               req_bus.valid <= 0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
            random_item();
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
